@@ design/ppdm_pkg.sv @@
// ----------------------------------------------------------------------------
// ppdm_pkg
// Shared constants and types for the pulse period and duty meter.
// ----------------------------------------------------------------------------
package ppdm_pkg;

   // capture counter width; only these low bits of a capture are used
   localparam int unsigned COUNTER_WIDTH = 32;
   localparam logic [31:0] CAP_MASK = 32'((64'd1 << COUNTER_WIDTH) - 64'd1);

   localparam logic [31:0] TOP_RESET  = 32'd65535;
   localparam logic [31:0] RATE_RESET = 32'd1000000;

   // configuration register indexes
   localparam logic [1:0] REG_COUNTER_TOP = 2'd0;
   localparam logic [1:0] REG_TICK_RATE   = 2'd1;

   // result status codes
   localparam logic [1:0] ST_WAITING = 2'd0;
   localparam logic [1:0] ST_DONE    = 2'd1;
   localparam logic [1:0] ST_EQUAL   = 2'd2;

   // measurement phases
   localparam logic [1:0] PH_FIRST_RISE = 2'd0;
   localparam logic [1:0] PH_FALL       = 2'd1;
   localparam logic [1:0] PH_NEXT_RISE  = 2'd2;

   localparam logic [5:0] FREQ_STEPS = 6'd32;
   localparam logic [5:0] DUTY_STEPS = 6'd17;

   // command to one serial divider
   typedef struct packed {
      logic        start;
      logic [5:0]  steps;     // quotient bits to produce
      logic [32:0] rem_init;  // starting partial remainder, below divisor
      logic [31:0] dividend;  // bits streamed in MSB first
      logic [32:0] divisor;
   } div_cmd_type;

endpackage

@@ design/ppdm_div.sv @@
// ----------------------------------------------------------------------------
// ppdm_div
// Bit-serial restoring divider: one quotient bit per clock, dividend bits
// shifted in MSB first behind a preset partial remainder.
// ----------------------------------------------------------------------------
module ppdm_div
   import ppdm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_cmd_type cmd,
   output logic        busy,
   output logic [31:0] quotient
);

   logic        run_ff, run_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [32:0] rem_ff, rem_in;
   logic [31:0] bits_ff, bits_in;
   logic [31:0] quo_ff, quo_in;
   logic [32:0] dvs_ff, dvs_in;

   logic [33:0] trial;
   logic [34:0] diff;
   logic        ge;

   assign trial = {rem_ff, bits_ff[31]};
   assign diff  = {1'b0, trial} - {2'b00, dvs_ff};
   assign ge    = ~diff[34];

   always_comb begin
      run_in  = run_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      bits_in = bits_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      if (cmd.start) begin
         run_in  = 1'b1;
         cnt_in  = cmd.steps;
         rem_in  = cmd.rem_init;
         bits_in = cmd.dividend;
         quo_in  = '0;
         dvs_in  = cmd.divisor;
      end else if (run_ff) begin
         // remainder stays below the divisor, so 33 bits hold it
         rem_in  = ge ? diff[32:0] : trial[32:0];
         bits_in = {bits_ff[30:0], 1'b0};
         quo_in  = {quo_ff[30:0], ge};
         cnt_in  = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            run_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         run_ff <= run_in;
         cnt_ff <= cnt_in;
      end
      rem_ff  <= rem_in;
      bits_ff <= bits_in;
      quo_ff  <= quo_in;
      dvs_ff  <= dvs_in;
   end

   assign busy     = run_ff;
   assign quotient = quo_ff;

endmodule

@@ design/pulse_period_duty_meter.sv @@
// ----------------------------------------------------------------------------
// pulse_period_duty_meter
// Period, frequency and duty of a pulse train from per-edge timer captures.
// ----------------------------------------------------------------------------
// Each request carries one capture value; each gives exactly one response.
// Edges cycle first rise, fall, next rise. A request that only stores an edge
// (or hits equal captures) goes from the difference step to the emit step; a
// closing edge passes the period step first and, on a nonzero period, the
// divide step, which waits for the 32-step frequency divider and the 17-step
// duty divider beside it. The next request is taken once the block is back in
// idle after its emit step. A response that waits on rsp_tready holds the
// block in its emit step only while the output register is still full.
// Otherwise the response register decouples the sides, so a new request is
// taken while a response waits. The user must write counter_top and tick_rate
// through the csr port only while idle; the block itself does not enforce it.
module pulse_period_duty_meter
   import ppdm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // request: capture_value[31:0]
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,
   // response: arm_falling[0], frequency[32:1], duty_q16[48:33],
   // period_ticks[81:49], zero fill[87:82]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [87:0] rsp_tdata,
   // response kind: status[1:0]
   output logic [1:0]  rsp_tuser,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_data
);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_DIFF   = 3'd1;
   localparam logic [2:0] S_PERIOD = 3'd2;
   localparam logic [2:0] S_DIV    = 3'd3;
   localparam logic [2:0] S_EMIT   = 3'd4;

   logic [2:0]  state_ff, state_in;
   logic [1:0]  phase_ff, phase_in;
   logic [31:0] top_ff, top_in;
   logic [31:0] rate_ff, rate_in;
   logic [31:0] cap_ff, cap_in;
   logic [31:0] last_ff, last_in;
   logic [32:0] high_ff, high_in;
   logic [32:0] low_ff, low_in;
   logic [1:0]  res_status_ff, res_status_in;
   logic        res_arm_ff, res_arm_in;
   logic [31:0] res_freq_ff, res_freq_in;
   logic [15:0] res_duty_ff, res_duty_in;
   logic [32:0] res_period_ff, res_period_in;
   logic        out_valid_ff, out_valid_in;
   logic [87:0] out_data_ff, out_data_in;
   logic [1:0]  out_user_ff, out_user_in;

   logic [33:0] wrap_sum;
   logic [32:0] wdiff;
   logic [33:0] period_sum;
   logic [32:0] period_sat;

   div_cmd_type freq_cmd, duty_cmd;
   logic        freq_busy, duty_busy;
   logic [31:0] freq_quo, duty_quo;

   ppdm_div u_freq_div (
      .clock    (clock),
      .reset    (reset),
      .cmd      (freq_cmd),
      .busy     (freq_busy),
      .quotient (freq_quo)
   );

   ppdm_div u_duty_div (
      .clock    (clock),
      .reset    (reset),
      .cmd      (duty_cmd),
      .busy     (duty_busy),
      .quotient (duty_quo)
   );

   // counter wrap: top + 1 + cur - last, modulo 2^33
   assign wrap_sum = {2'b00, top_ff} + 34'd1 + {2'b00, cap_ff} - {2'b00, last_ff};
   assign wdiff    = (cap_ff > last_ff) ? {1'b0, cap_ff - last_ff} : wrap_sum[32:0];

   assign period_sum = {1'b0, high_ff} + {1'b0, low_ff};
   assign period_sat = period_sum[33] ? '1 : period_sum[32:0];

   always_comb begin
      freq_cmd.start    = 1'b0;
      freq_cmd.steps    = FREQ_STEPS;
      freq_cmd.rem_init = '0;
      freq_cmd.dividend = rate_ff;
      freq_cmd.divisor  = period_sat;
      // high <= period, so high >> 1 is a valid starting remainder
      duty_cmd.start    = 1'b0;
      duty_cmd.steps    = DUTY_STEPS;
      duty_cmd.rem_init = {1'b0, high_ff[32:1]};
      duty_cmd.dividend = {high_ff[0], 31'd0};
      duty_cmd.divisor  = period_sat;

      state_in      = state_ff;
      phase_in      = phase_ff;
      top_in        = top_ff;
      rate_in       = rate_ff;
      cap_in        = cap_ff;
      last_in       = last_ff;
      high_in       = high_ff;
      low_in        = low_ff;
      res_status_in = res_status_ff;
      res_arm_in    = res_arm_ff;
      res_freq_in   = res_freq_ff;
      res_duty_in   = res_duty_ff;
      res_period_in = res_period_ff;
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      out_user_in   = out_user_ff;

      if (csr_valid) begin
         case (csr_index)
            REG_COUNTER_TOP: top_in  = csr_data;
            REG_TICK_RATE:   rate_in = csr_data;
            default: ;
         endcase
      end

      if (out_valid_ff && rsp_tready) begin
         out_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cap_in   = req_tdata & CAP_MASK;
               state_in = S_DIFF;
            end
         end
         S_DIFF: begin
            res_status_in = ST_WAITING;
            res_arm_in    = 1'b0;
            res_freq_in   = '0;
            res_duty_in   = '0;
            res_period_in = '0;
            state_in      = S_EMIT;
            if (phase_ff != PH_FALL && phase_ff != PH_NEXT_RISE) begin
               last_in    = cap_ff;
               phase_in   = PH_FALL;
               res_arm_in = 1'b1;
            end else if (cap_ff == last_ff) begin
               res_status_in = ST_EQUAL;
               phase_in      = PH_FIRST_RISE;
            end else if (phase_ff == PH_FALL) begin
               high_in  = wdiff;
               last_in  = cap_ff;
               phase_in = PH_NEXT_RISE;
            end else begin
               low_in   = wdiff;
               state_in = S_PERIOD;
            end
         end
         S_PERIOD: begin
            phase_in      = PH_FIRST_RISE;
            res_status_in = ST_DONE;
            res_period_in = period_sat;
            if (period_sat == '0) begin
               res_freq_in = '1;
               res_duty_in = '0;
               state_in    = S_EMIT;
            end else begin
               freq_cmd.start = 1'b1;
               duty_cmd.start = 1'b1;
               state_in       = S_DIV;
            end
         end
         S_DIV: begin
            if (!freq_busy && !duty_busy) begin
               res_freq_in = freq_quo;
               // a full-high pulse gives 65536, clamp to the top code
               res_duty_in = duty_quo[16] ? 16'hFFFF : duty_quo[15:0];
               state_in    = S_EMIT;
            end
         end
         S_EMIT: begin
            if (!out_valid_ff || rsp_tready) begin
               out_valid_in = 1'b1;
               out_user_in  = res_status_ff;
               out_data_in  = {6'd0, res_period_ff, res_duty_ff, res_freq_ff, res_arm_ff};
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         phase_ff     <= PH_FIRST_RISE;
         top_ff       <= TOP_RESET;
         rate_ff      <= RATE_RESET;
         last_ff      <= '0;
         high_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         top_ff       <= top_in;
         rate_ff      <= rate_in;
         last_ff      <= last_in;
         high_ff      <= high_in;
         out_valid_ff <= out_valid_in;
      end
      cap_ff        <= cap_in;
      low_ff        <= low_in;
      res_status_ff <= res_status_in;
      res_arm_ff    <= res_arm_in;
      res_freq_ff   <= res_freq_in;
      res_duty_ff   <= res_duty_in;
      res_period_ff <= res_period_in;
      out_data_ff   <= out_data_in;
      out_user_ff   <= out_user_in;
   end

   assign req_tready = (state_ff == S_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tuser  = out_user_ff;

endmodule
